// ----- sv/dbr_pkg.sv -----
// Shared types and constants for the depth buffer to range converter.
package dbr_pkg;

	localparam int MAX_DIM_DEF    = 4096;
	localparam int DEPTH_BITS_DEF = 24;

	// Field widths fixed by the stream format
	localparam int POS_W  = 12;
	localparam int DIM_W  = 13;
	localparam int FIX_W  = 32;
	localparam int HALF_W = 15;
	localparam int HSQ_W  = 28;

	// Radicand f^2 + (hx*2^15)^2 + (hy*2^15)^2 stays below 2^65
	localparam int SUM_W  = 66;
	localparam int ROOT_W = 33;
	localparam int PAD_N  = ROOT_W - FIX_W;
	localparam int PROD_W = FIX_W + ROOT_W;

	localparam logic [FIX_W-1:0] NEAR_RST  = 32'd6554;
	localparam logic [FIX_W-1:0] FAR_RST   = 32'd655360;
	localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [FIX_W-1:0] FOCAL_RST = 32'd34406400;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR   = 3'd0,
		CFG_FAR    = 3'd1,
		CFG_WIDTH  = 3'd2,
		CFG_HEIGHT = 3'd3,
		CFG_FOCAL  = 3'd4
	} cfg_idx_t;

endpackage

// ----- sv/dbr_div_cell.sv -----
// One restoring division cell: develops one quotient bit per stage.
module dbr_div_cell
	import dbr_pkg::*;
#(
	parameter int W  = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  rem_i,
	input  logic [W-1:0]  dvs_i,
	input  logic [QW-1:0] low_i,
	input  logic [QW-1:0] q_i,
	output logic [W-1:0]  rem_o,
	output logic [W-1:0]  dvs_o,
	output logic [QW-1:0] low_o,
	output logic [QW-1:0] q_o
);

	logic [W:0] remx;
	logic [W:0] diff;
	logic       ge;

	// remainder stays below the divisor, so the shifted value fits W+1 bits
	assign remx = {rem_i, low_i[QW-1]};
	assign diff = remx - {1'b0, dvs_i};
	assign ge   = remx >= {1'b0, dvs_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[W-1:0] : remx[W-1:0];
			dvs_o <= dvs_i;
			low_o <= {low_i[QW-2:0], 1'b0};
			q_o   <= {q_i[QW-2:0], ge};
		end
	end

endmodule

// ----- sv/dbr_sqrt_cell.sv -----
// One digit-by-digit square root cell: decides root bit B.
module dbr_sqrt_cell
	import dbr_pkg::*;
#(
	parameter int B = 0
) (
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  rem_i,
	input  logic [ROOT_W-1:0] root_i,
	output logic [SUM_W-1:0]  rem_o,
	output logic [ROOT_W-1:0] root_o
);

	localparam int IW = SUM_W + 2;

	logic [IW-1:0] inc;
	logic [IW-1:0] remx;
	logic [IW-1:0] diff;
	logic          ge;

	// (r + 2^B)^2 - r^2, with r holding bits above B only
	assign inc  = (IW'(root_i) << (B + 1)) + (IW'(1) << (2 * B));
	assign remx = IW'(rem_i);
	assign diff = remx - inc;
	assign ge   = remx >= inc;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[SUM_W-1:0] : rem_i;
			root_o <= ge ? (root_i | (ROOT_W'(1) << B)) : root_i;
		end
	end

endmodule

// ----- sv/depth_buffer_to_range.sv -----
// Top level: depth sample to radial distance, a chain of bit cells.
//
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid/s_tready    depth_sample, column, buffer_row
// m_*       out  m_tvalid/m_tready    distance, image_row, image_column; tuser saturated
// cfg_*     in   cfg_valid/cfg_ready  register index and write data
//
// One item per cycle unless the output stalls; items pass stages 1 and 2, the square
// root chain (one root bit per cell), the products and the 32-cell distance divider.
// Reset clears the stage valid bits and loads the register defaults.
// A result held at the output freezes the whole chain, input included; bubbles stay put.
module depth_buffer_to_range
	import dbr_pkg::*;
#(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// depth_sample, column, buffer_row
	input  logic [((DEPTH_BITS+2*POS_W+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// distance, image_row, image_column
	output logic [55:0]           m_tdata,
	// saturated
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FIX_W-1:0]      cfg_data
);

	localparam int DB = DEPTH_BITS;
	localparam int DW = FIX_W + DEPTH_BITS;     // linearization divisor width
	localparam int NL = 4 + ROOT_W + FIX_W;     // pipeline depth
	localparam int M2 = 3 + ROOT_W;             // index of the product stage

	// configuration registers
	logic [FIX_W-1:0] near_q, far_q, focal_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] dim_clamped;

	assign cfg_ready   = 1'b1;
	assign dim_clamped = ({19'b0, cfg_data[DIM_W-1:0]} > 32'(MAX_DIM_DEF)) ?
		DIM_W'(MAX_DIM_DEF) : cfg_data[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			focal_q  <= FOCAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NEAR:   near_q   <= cfg_data;
				CFG_FAR:    far_q    <= cfg_data;
				CFG_WIDTH:  width_q  <= dim_clamped;
				CFG_HEIGHT: height_q <= dim_clamped;
				CFG_FOCAL:  focal_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// flow control: the chain moves unless a result is waiting
	logic          en;
	logic [NL-1:0] v_q;

	assign en       = !v_q[NL-1] || m_tready;
	assign s_tready = en;

	// input fields
	logic [DB-1:0]    in_d;
	logic [POS_W-1:0] in_col, in_row;

	assign in_d   = s_tdata[DB-1:0];
	assign in_col = s_tdata[DB+POS_W-1:DB];
	assign in_row = s_tdata[DB+2*POS_W-1:DB+POS_W];

	// half-pixel offsets from the image center
	logic signed [HALF_W-1:0] hx, hy;
	logic [HALF_W-2:0]        hx_abs, hy_abs;
	logic [DB:0]              one_minus_d;

	assign hx = $signed({2'b0, in_col, 1'b0}) - $signed({2'b0, width_q}) + HALF_W'(1);
	assign hy = $signed({2'b0, in_row, 1'b0}) - $signed({2'b0, height_q}) + HALF_W'(1);
	assign hx_abs = hx[HALF_W-1] ? (HALF_W-1)'(-hx) : hx[HALF_W-2:0];
	assign hy_abs = hy[HALF_W-1] ? (HALF_W-1)'(-hy) : hy[HALF_W-2:0];
	assign one_minus_d = {1'b1, {DB{1'b0}}} - {1'b0, in_d};

	// stage 1: products
	logic [DW-1:0]      fd_s1, dn_s1;
	logic [2*FIX_W-1:0] nf_s1, ff_s1;
	logic [HSQ_W-1:0]   ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			fd_s1 <= DW'(far_q * one_minus_d);
			dn_s1 <= DW'(in_d * near_q);
			nf_s1 <= near_q * far_q;
			ff_s1 <= focal_q * focal_q;
			ax_s1 <= hx_abs * hx_abs;
			ay_s1 <= hy_abs * hy_abs;
		end
	end

	// stage 2: divisor, numerator and radicand
	logic [DW-1:0]      den_c;
	logic [DW-1:0]      den_s2;
	logic [2*FIX_W-1:0] nf_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic [2*FIX_W+DB-1:0] num;

	assign den_c = DW'(fd_s1 + dn_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= den_c;
			nf_s2  <= nf_s1;
			sum_s2 <= SUM_W'(ff_s1) + (SUM_W'(ax_s1) << 30) + (SUM_W'(ay_s1) << 30);
		end
	end

	assign num = {nf_s2, {DB{1'b0}}};

	// plane distance divider: 32 cells, one quotient bit each
	logic [DW-1:0]    pr_rem [FIX_W+1];
	logic [DW-1:0]    pr_dvs [FIX_W+1];
	logic [FIX_W-1:0] pr_low [FIX_W+1];
	logic [FIX_W-1:0] pr_q   [FIX_W+1];

	assign pr_rem[0] = num[FIX_W+DW-1:FIX_W];
	assign pr_dvs[0] = den_s2;
	assign pr_low[0] = num[FIX_W-1:0];
	assign pr_q[0]   = '0;

	for (genvar i = 0; i < FIX_W; i++) begin : g_plane
		dbr_div_cell #(.W(DW), .QW(FIX_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (pr_rem[i]),
			.dvs_i (pr_dvs[i]),
			.low_i (pr_low[i]),
			.q_i   (pr_q[i]),
			.rem_o (pr_rem[i+1]),
			.dvs_o (pr_dvs[i+1]),
			.low_o (pr_low[i+1]),
			.q_o   (pr_q[i+1])
		);
	end

	// pad the plane result to the length of the root chain
	logic [FIX_W-1:0] plane_pad_q [PAD_N];

	always_ff @(posedge clk) begin
		if (en) begin
			plane_pad_q[0] <= pr_q[FIX_W];
			for (int k = 1; k < PAD_N; k++) plane_pad_q[k] <= plane_pad_q[k-1];
		end
	end

	// square root chain, most significant root bit first
	logic [SUM_W-1:0]  sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];

	assign sq_rem[0]  = sum_s2;
	assign sq_root[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		dbr_sqrt_cell #(.B(ROOT_W - 1 - j)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sq_rem[j]),
			.root_i (sq_root[j]),
			.rem_o  (sq_rem[j+1]),
			.root_o (sq_root[j+1])
		);
	end

	// plane * diag, split into two partial products in plo_m1/phi_m1, summed into prod_m2
	logic [2*FIX_W-1:0] plo_m1;
	logic [ROOT_W-1:0]  phi_m1;
	logic [PROD_W-1:0]  prod_c;
	logic [2*FIX_W-1:0] prod_m2;
	logic               ovf_c;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_m1 <= plane_pad_q[PAD_N-1] * sq_root[ROOT_W][FIX_W-1:0];
			phi_m1 <= ROOT_W'(plane_pad_q[PAD_N-1] * sq_root[ROOT_W][ROOT_W-1:FIX_W]);
		end
	end

	assign prod_c = PROD_W'(plo_m1) + (PROD_W'(phi_m1) << FIX_W);
	// quotient would not fit 32 bits
	assign ovf_c  = prod_c[PROD_W-1:FIX_W] >= ROOT_W'(focal_q);

	// top product bit only matters on overflow, which the flag already covers
	always_ff @(posedge clk) begin
		if (en) prod_m2 <= prod_c[2*FIX_W-1:0];
	end

	// distance divider by the focal length
	logic [FIX_W-1:0] ds_rem [FIX_W+1];
	logic [FIX_W-1:0] ds_dvs [FIX_W+1];
	logic [FIX_W-1:0] ds_low [FIX_W+1];
	logic [FIX_W-1:0] ds_q   [FIX_W+1];

	assign ds_rem[0] = prod_m2[2*FIX_W-1:FIX_W];
	assign ds_dvs[0] = focal_q;
	assign ds_low[0] = prod_m2[FIX_W-1:0];
	assign ds_q[0]   = '0;

	for (genvar i = 0; i < FIX_W; i++) begin : g_dist
		dbr_div_cell #(.W(FIX_W), .QW(FIX_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (ds_rem[i]),
			.dvs_i (ds_dvs[i]),
			.low_i (ds_low[i]),
			.q_i   (ds_q[i]),
			.rem_o (ds_rem[i+1]),
			.dvs_o (ds_dvs[i+1]),
			.low_o (ds_low[i+1]),
			.q_o   (ds_q[i+1])
		);
	end

	// sideband travels beside the cells
	logic [POS_W-1:0] sb_col_q [NL];
	logic [POS_W-1:0] sb_row_q [NL];
	logic             sb_sat_q [NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NL-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_col_q[0] <= in_col;
			sb_row_q[0] <= POS_W'(height_q - DIM_W'(1) - {1'b0, in_row});
			// zero focal length
			sb_sat_q[0] <= (focal_q == '0);
			for (int k = 1; k < NL; k++) begin
				sb_col_q[k] <= sb_col_q[k-1];
				sb_row_q[k] <= sb_row_q[k-1];
			end
			for (int k = 2; k < NL; k++) begin
				if (k != M2) sb_sat_q[k] <= sb_sat_q[k-1];
			end
			// zero divisor
			sb_sat_q[1]  <= sb_sat_q[0] || (den_c == '0);
			sb_sat_q[M2] <= sb_sat_q[M2-1] || ovf_c;
		end
	end

	assign m_tvalid = v_q[NL-1];
	assign m_tuser  = sb_sat_q[NL-1];
	assign m_tdata  = {sb_col_q[NL-1], sb_row_q[NL-1],
		sb_sat_q[NL-1] ? {FIX_W{1'b1}} : ds_q[FIX_W]};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_q[0])
		else $error("accepted item did not enter the chain");

	a_idle_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		en && !s_tvalid |=> !v_q[0])
		else $error("item appeared without an accept");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("chain moved during a stall");

	a_stall_count: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $countones(v_q) == $past($countones(v_q)))
		else $error("item lost or duplicated during a stall");

endmodule

// ----- dv/range_checker.sv -----
// Checker for the depth-to-range converter: predicts each result and compares the output stream.
module range_checker
	import dbr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [47:0]        s_tdata,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [55:0]        m_tdata,
	input  logic               m_tuser,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIX_W-1:0]   cfg_data,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] distance;
		logic [11:0] image_row;
		logic [11:0] image_column;
		logic        saturated;
	} range_t;

	range_t expected_ranges[$];
	logic [31:0] near_q, far_q, focal_q;
	logic [12:0] width_q, height_q;

	assign pending = expected_ranges.size();

	function automatic logic [127:0] half_offset_sq(logic [11:0] pos, logic [12:0] dim);
		longint h;
		longint m;
		h = 2 * longint'(pos) - longint'(dim) + 1;
		m = (h < 0) ? -h : h;
		return 128'(m * m) << 30;
	endfunction

	function automatic range_t predict_range(logic [23:0] dep, logic [11:0] col,
		logic [11:0] row);
		range_t r;
		logic [127:0] den, plane, s, t, q;
		logic [127:0] root;
		den = 128'(far_q) * ((128'd1 << 24) - 128'(dep)) + 128'(dep) * 128'(near_q);
		r.distance = 32'hFFFF_FFFF;
		r.saturated = 1'b1;
		if (den != 0 && focal_q != 0) begin
			plane = ((128'(near_q) * 128'(far_q)) << 24) / den;
			plane = {64'd0, plane[63:0]};
			s = 128'(focal_q) * 128'(focal_q) + half_offset_sq(col, width_q)
				+ half_offset_sq(row, height_q);
			root = 0;
			for (int b = 33; b >= 0; b--) begin
				t = root | (128'd1 << b);
				if (t * t <= s) root = t;
			end
			q = (plane * root) / 128'(focal_q);
			if (q <= 128'hFFFF_FFFF) begin
				r.distance = q[31:0];
				r.saturated = 1'b0;
			end
		end
		r.image_row = 12'(height_q - 13'd1 - 13'(row));
		r.image_column = col;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			focal_q  <= FOCAL_RST;
			errors   <= 0;
		end else begin
			// registers must only change while no item is in flight; this checker does not enforce it
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NEAR:   near_q <= cfg_data;
					CFG_FAR:    far_q <= cfg_data;
					CFG_WIDTH:  width_q <= (cfg_data[12:0] > 13'd4096) ? 13'd4096 : cfg_data[12:0];
					CFG_HEIGHT: height_q <= (cfg_data[12:0] > 13'd4096) ? 13'd4096 : cfg_data[12:0];
					CFG_FOCAL:  focal_q <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_ranges.insert(expected_ranges.size(),
					predict_range(s_tdata[23:0], s_tdata[35:24], s_tdata[47:36]));
			if (m_tvalid && m_tready) begin
				range_t e;
				int bad;
				bad = 0;
				if (expected_ranges.size() == 0) begin
					$error("result with no item outstanding: tdata %h", m_tdata);
					bad = 1;
				end else begin
					e = expected_ranges.pop_front();
					if (m_tdata[31:0] !== e.distance) begin
						$error("distance: expected %h, got %h", e.distance, m_tdata[31:0]);
						bad++;
					end
					if (m_tdata[43:32] !== e.image_row) begin
						$error("image_row: expected %0d, got %0d", e.image_row, m_tdata[43:32]);
						bad++;
					end
					if (m_tdata[55:44] !== e.image_column) begin
						$error("image_column: expected %0d, got %0d", e.image_column,
							m_tdata[55:44]);
						bad++;
					end
					if (m_tuser !== e.saturated) begin
						$error("saturated: expected %b, got %b", e.saturated, m_tuser);
						bad++;
					end
				end
				errors <= errors + bad;
			end
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: stimulus, configuration phases and verdict for depth_buffer_to_range.
module tb_top
	import dbr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// an index past the register list; the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 90;   // pipeline is 69 deep

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [47:0]          s_tdata;    // depth_sample[23:0], column[35:24], buffer_row[47:36]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;    // distance[31:0], image_row[43:32], image_column[55:44]
	logic                 m_tuser;    // saturated
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIX_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   send_idle_pct;
	int                   stall_pct;

	depth_buffer_to_range DUT (.*);

	range_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver back-pressure, re-rolled every cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// send one item; valid stays high across back-to-back items
	task automatic send_sample(logic [23:0] dep, logic [11:0] col, logic [11:0] row);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row, col, dep};
		do @(posedge clk); while (!s_tready);
	endtask

	// caller lowers cfg_valid after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(logic [31:0] nr, logic [31:0] fr, logic [31:0] w,
		logic [31:0] h, logic [31:0] f);
		write_reg(CFG_NEAR, nr);
		write_reg(CFG_FAR, fr);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_FOCAL, f);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// corners, center and depth extremes under the current setting
	task automatic corner_items();
		send_sample(24'd0, 12'd0, 12'd0);
		send_sample(24'hFFFFFF, 12'hFFF, 12'hFFF);
		send_sample(24'd0, 12'hFFF, 12'd0);
		send_sample(24'hFFFFFF, 12'd0, 12'hFFF);
		send_sample(24'h800000, 12'd320, 12'd240);
		send_sample(24'd1, 12'd639, 12'd479);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NEAR;
		cfg_data  = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 61; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 61; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			case (ph)
				0: ;  // reset defaults
				1: load_setting(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
				// near beyond far, largest image and focal length
				2: load_setting(32'hFFFF_FFFF, 32'd1, 32'd4096, 32'd4096, 32'hFFFF_FFFF);
				// far clip zero; oversized dimensions clamp
				3: load_setting(32'd6554, 32'd0, 32'h1FFF, 32'd5000, 32'd65536);
				// focal length zero, plus a write to an unused index
				4: begin
					write_reg(CFG_SPARE, $urandom);
					load_setting(32'd65536, 32'd6553600, 32'd640, 32'd480, 32'd0);
				end
				default: load_setting($urandom_range(1, 32'hFFFF_FFFF),
					$urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 4096),
					$urandom_range(1, 4096), $urandom_range(1, 32'hFFFF_FFFF));
			endcase
			if (ph < 4) corner_items();
			for (int i = 0; i < 144; i++) begin
				logic [23:0] dep;
				case ($urandom_range(0, 7))
					0: dep = 24'd0;
					1: dep = 24'hFFFFFF;
					default: dep = 24'($urandom_range(0, 24'hFFFFFF));
				endcase
				send_sample(dep, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
				// let the pipe run dry once mid-phase
				if (i == 60) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
